>>> sv/scbd_pkg.sv
// Shared constants and types for the sparse channel block decoder.
package scbd_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int WORD_W       = 32;
  localparam int VALUE_W      = 24;
  localparam int CHAN_W       = 6;
  localparam int COUNT_W      = 7;
  localparam int RATE_W       = 18;
  localparam int FMT_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 18;
  localparam int MASK_W       = 64;
  localparam int BYTE_IDX_W   = 4;

  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_F32 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd2;

  localparam logic [COUNT_W-1:0] RESET_CHANNEL_COUNT = 7'd2;
  localparam logic [RATE_W-1:0]  RESET_SAMPLE_RATE   = 18'd48000;

  typedef struct packed {
    logic              sample_valid;
    logic [CHAN_W-1:0] channel_index;
    logic              frame_last;
    logic              word_consumed;
  } step_ctl_t;

endpackage

>>> sv/sparse_channel_block_decoder.sv
// Top level of the sparse channel block decoder: config, input and result registers.
//
// Usage: each input item offers the next stream word (file_word) and asks for one
// step. Every item yields exactly one result item. At the start of each block the
// block takes one layout byte per eight channels, then emits sample_rate frames of
// channel_count samples. word_consumed low means the same word must be offered
// again as the next item; an absent channel returns a zero sample.
// Channels: in_valid/in_stall carry file_word; out_valid/out_stall carry the result
// fields. An item moves when valid is high and stall is low.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while out_stall is low; the step logic (mask test,
// counter update and constant-scaled conversion) fits between the two registers.
// Stall: while out_stall holds a full result register, the input register keeps its
// item and in_stall rises, so nothing is lost or repeated.
// Reset: a layout block is expected first; the registers return to
// channel_count 2, sample_rate 48000, sample_format unsigned 8-bit.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once and
// are expected only while the block is idle.
module sparse_channel_block_decoder
  import scbd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [WORD_W-1:0]         file_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      sample_valid,
  output logic signed [VALUE_W-1:0] sample_value,
  output logic [CHAN_W-1:0]         channel_index,
  output logic                      frame_last,
  output logic                      word_consumed
);

  logic [COUNT_W-1:0] channel_count;
  logic [RATE_W-1:0]  sample_rate;
  logic [FMT_W-1:0]   sample_format;

  logic               stage_valid;
  logic [WORD_W-1:0]  stage_word;
  logic               advance;
  logic               move;

  step_ctl_t                 ctl;
  logic                      present;
  logic signed [VALUE_W-1:0] conv_value;

  assign advance  = !out_valid || !out_stall;
  assign move     = stage_valid && advance;
  assign in_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= RESET_CHANNEL_COUNT;
      sample_rate   <= RESET_SAMPLE_RATE;
      sample_format <= FMT_U8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
        REG_SAMPLE_RATE:   sample_rate   <= cfg_data[RATE_W-1:0];
        REG_SAMPLE_FORMAT: sample_format <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_word <= file_word;
    end
  end

  scbd_sequencer u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (move),
    .layout_byte   (stage_word[7:0]),
    .channel_count (channel_count),
    .sample_rate   (sample_rate),
    .ctl           (ctl),
    .present       (present)
  );

  scbd_convert u_conv (
    .word          (stage_word),
    .sample_format (sample_format),
    .value         (conv_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sample_valid  <= ctl.sample_valid;
      channel_index <= ctl.channel_index;
      frame_last    <= ctl.frame_last;
      word_consumed <= ctl.word_consumed;
      sample_value  <= (ctl.sample_valid && present) ? conv_value : '0;
    end
  end

endmodule

>>> sv/scbd_convert.sv
// Sample word to Q2.22 conversion for the three word formats.
module scbd_convert
  import scbd_pkg::*;
(
  input  logic [WORD_W-1:0]         word,
  input  logic [FMT_W-1:0]          sample_format,
  output logic signed [VALUE_W-1:0] value
);

  logic [7:0]          u8;
  logic [9:0]          u8_t;
  logic [2:0]          u8_q;
  logic [VALUE_W-1:0]  u8_val;

  logic                s_neg;
  logic [16:0]         s_mag;
  logic [22:0]         s_x;
  logic [7:0]          s_a;
  logic [15:0]         s_ab;
  logic [22:0]         s_q;
  logic [VALUE_W-1:0]  s_val;

  logic                f_neg;
  logic [7:0]          f_exp;
  logic [22:0]         f_frac;
  logic [7:0]          f_k8;
  logic [4:0]          f_k;
  logic [30:0]         f_sum;
  logic [30:0]         f_mag;
  logic [VALUE_W:0]    f_lim;
  logic [VALUE_W-1:0]  f_val;

  // u/127 - 1: u*2^22 = 127*33025*u + 129*u, the remainder term folds to u + (2u+63)/127
  always_comb begin
    u8   = word[7:0];
    u8_t = {1'b0, u8, 1'b0} + 10'd63;
    if (u8_t >= 10'd508) u8_q = 3'd4;
    else if (u8_t >= 10'd381) u8_q = 3'd3;
    else if (u8_t >= 10'd254) u8_q = 3'd2;
    else if (u8_t >= 10'd127) u8_q = 3'd1;
    else u8_q = 3'd0;
    u8_val = 24'(u8) * 24'd33026 + 24'(u8_q) - 24'd4194304;
  end

  // s/32767: q = 128m + floor((128m+16383)/32767), divisor is 2^15-1
  always_comb begin
    s_neg = word[15];
    s_mag = s_neg ? (17'h10000 - {1'b0, word[15:0]}) : {1'b0, word[15:0]};
    s_x   = {s_mag[15:0], 7'd0} + 23'd16383;
    s_a   = s_x[22:15];
    s_ab  = {8'd0, s_a} + {1'b0, s_x[14:0]};
    s_q   = {s_mag[15:0], 7'd0} + 23'(s_a) + 23'(s_ab >= 16'd32767);
    s_val = s_neg ? (24'd0 - {1'b0, s_q}) : {1'b0, s_q};
  end

  // float32 scaled by 2^22, round half away, saturate, NaN to zero
  always_comb begin
    f_neg  = word[31];
    f_exp  = word[30:23];
    f_frac = word[22:0];
    f_k8   = 8'd128 - f_exp;
    f_k    = f_k8[4:0];
    f_sum  = {7'd0, 1'b1, f_frac} + (31'd1 << (f_k - 5'd1));
    f_mag  = f_sum >> f_k;
    f_val  = '0;
    f_lim  = '0;
    if (f_exp == 8'hFF) begin
      if (f_frac != '0) f_val = '0;
      else f_val = f_neg ? 24'h800000 : 24'h7FFFFF;
    end else if (f_exp == 8'd0) begin
      f_val = '0;
    end else if (f_exp >= 8'd128) begin
      f_val = f_neg ? 24'h800000 : 24'h7FFFFF;
    end else if (f_k8 > 8'd30) begin
      f_val = '0;
    end else if (f_neg) begin
      f_lim = (f_mag > 31'd8388608) ? 25'd8388608 : f_mag[VALUE_W:0];
      f_val = 24'(25'd0 - f_lim);
    end else begin
      f_val = (f_mag > 31'd8388607) ? 24'h7FFFFF : f_mag[VALUE_W-1:0];
    end
  end

  always_comb begin
    case (sample_format)
      FMT_U8:  value = signed'(u8_val);
      FMT_S16: value = signed'(s_val);
      default: value = signed'(f_val);
    endcase
  end

endmodule

>>> sv/scbd_sequencer.sv
// Layout and frame sequencing: channel mask, channel counter and frame counter.
module scbd_sequencer
  import scbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         layout_byte,
  input  logic [COUNT_W-1:0] channel_count,
  input  logic [RATE_W-1:0]  sample_rate,
  output step_ctl_t          ctl,
  output logic               present
);

  logic [MASK_W-1:0]     channel_present, channel_present_next;
  logic [BYTE_IDX_W-1:0] layout_byte_index, layout_byte_index_next;
  logic                  in_layout_phase, in_layout_phase_next;
  logic [CHAN_W-1:0]     current_channel, current_channel_next;
  logic [RATE_W-1:0]     frames_left, frames_left_next;

  logic [COUNT_W-1:0]    n_eff;
  logic [COUNT_W-1:0]    n_m1;
  logic [COUNT_W-1:0]    n_round;
  logic [BYTE_IDX_W-1:0] n_bytes;
  logic [2:0]            k;
  logic [BYTE_IDX_W-1:0] k_inc;
  logic [MASK_W-1:0]     count_mask;
  logic [MASK_W-1:0]     byte_bits;
  logic [CHAN_W-1:0]     chan;
  logic                  last;
  logic [RATE_W-1:0]     frames_dec;

  always_comb begin
    if (channel_count == '0) n_eff = 7'd1;
    else if (channel_count > COUNT_W'(MAX_CHANNELS)) n_eff = COUNT_W'(MAX_CHANNELS);
    else n_eff = channel_count;
    n_m1    = n_eff - 7'd1;
    n_round = n_eff + 7'd7;
    n_bytes = BYTE_IDX_W'(n_round >> 3);
    for (int i = 0; i < MASK_W; i++) begin
      count_mask[i] = (i < int'(n_eff));
    end
    k         = layout_byte_index[2:0];
    k_inc     = {1'b0, k} + 4'd1;
    byte_bits = (MASK_W'(layout_byte) << {k, 3'b000}) & count_mask;
    chan      = ({1'b0, current_channel} >= n_eff) ? n_m1[CHAN_W-1:0] : current_channel;
    last      = (chan == n_m1[CHAN_W-1:0]);
    present   = channel_present[chan];
    frames_dec = (frames_left != '0) ? frames_left - 18'd1 : '0;
  end

  always_comb begin
    channel_present_next   = channel_present;
    layout_byte_index_next = layout_byte_index;
    in_layout_phase_next   = in_layout_phase;
    current_channel_next   = current_channel;
    frames_left_next       = frames_left;
    if (in_layout_phase) begin
      channel_present_next = ((k == 3'd0) ? '0 : channel_present) | byte_bits;
      if (k_inc >= n_bytes) begin
        in_layout_phase_next   = 1'b0;
        layout_byte_index_next = '0;
        current_channel_next   = '0;
        frames_left_next       = (sample_rate == '0) ? 18'd1 : sample_rate;
      end else begin
        layout_byte_index_next = k_inc;
      end
    end else if (last) begin
      current_channel_next = '0;
      frames_left_next     = frames_dec;
      if (frames_dec == '0) begin
        in_layout_phase_next   = 1'b1;
        layout_byte_index_next = '0;
      end
    end else begin
      current_channel_next = chan + 6'd1;
    end
  end

  always_comb begin
    if (in_layout_phase) begin
      ctl.sample_valid  = 1'b0;
      ctl.channel_index = '0;
      ctl.frame_last    = 1'b0;
      ctl.word_consumed = 1'b1;
    end else begin
      ctl.sample_valid  = 1'b1;
      ctl.channel_index = chan;
      ctl.frame_last    = last;
      ctl.word_consumed = present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_present   <= '0;
      layout_byte_index <= '0;
      in_layout_phase   <= 1'b1;
      current_channel   <= '0;
      frames_left       <= '0;
    end else if (step) begin
      channel_present   <= channel_present_next;
      layout_byte_index <= layout_byte_index_next;
      in_layout_phase   <= in_layout_phase_next;
      current_channel   <= current_channel_next;
      frames_left       <= frames_left_next;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sparse channel block decoder.
module testbench;
  import scbd_pkg::*;

  localparam logic [FMT_W-1:0] FMT_CODE3 = 2'd3;
  localparam longint Q22_MAX = 8388607;
  localparam longint Q22_MIN = -8388608;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [CHAN_W-1:0]         chan;
    logic                      last;
    logic                      used;
  } sample_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_CHANNEL_COUNT;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [WORD_W-1:0]         file_word = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      sample_valid;
  logic signed [VALUE_W-1:0] sample_value;
  logic [CHAN_W-1:0]         channel_index;
  logic                      frame_last;
  logic                      word_consumed;

  sparse_channel_block_decoder dut (.*);

  always #4 clk = ~clk;

  // decoder state as tracked by the testbench
  logic [COUNT_W-1:0]    cnt_reg = RESET_CHANNEL_COUNT;
  logic [RATE_W-1:0]     rate_reg = RESET_SAMPLE_RATE;
  logic [FMT_W-1:0]      fmt_reg = FMT_U8;
  logic [MASK_W-1:0]     present = '0;
  logic [BYTE_IDX_W-1:0] byte_idx = '0;
  logic                  layout_phase = 1'b1;
  logic [CHAN_W-1:0]     cur_ch = '0;
  logic [RATE_W-1:0]     frames_left = '0;

  sample_t pending[$];
  int      fail_count = 0;
  logic    steady = 1'b0;
  int      stall_hold = 0;

  function automatic int unsigned active_channels();
    int unsigned n;
    n = 32'(cnt_reg);
    if (n < 1) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    return n;
  endfunction

  function automatic longint float_to_q22(logic [31:0] w);
    longint mant, mag;
    int     sh, k;
    mant = longint'(w[22:0]);
    if (w[30:23] == 8'hFF) begin
      if (mant != 0) return 0;
      return w[31] ? Q22_MIN : Q22_MAX;
    end
    if (w[30:23] == 8'h00) begin
      sh = -127;
    end else begin
      mant = mant | (longint'(1) << 23);
      sh = int'(w[30:23]) - 128;
    end
    if (sh >= 0) begin
      if (mant == 0) return 0;
      return w[31] ? Q22_MIN : Q22_MAX;
    end
    k = -sh;
    if (k > 30) return 0;
    mag = (mant + (longint'(1) << (k - 1))) >>> k;
    if (w[31]) begin
      if (mag > 8388608) mag = 8388608;
      return -mag;
    end
    if (mag > Q22_MAX) mag = Q22_MAX;
    return mag;
  endfunction

  function automatic longint to_q22(logic [31:0] w);
    longint n;
    case (fmt_reg)
      FMT_U8: begin
        n = longint'(w[7:0]) << 22;
        return (n + 63) / 127 - (longint'(1) << 22);
      end
      FMT_S16: begin
        if (w[15]) begin
          n = (65536 - longint'(w[15:0])) << 22;
          return -((n + 16383) / 32767);
        end
        n = longint'(w[15:0]) << 22;
        return (n + 16383) / 32767;
      end
      default: return float_to_q22(w);
    endcase
  endfunction

  // one decoder step: updates the tracked state, returns the result item
  function automatic sample_t decode_step(logic [31:0] w);
    sample_t          r;
    int unsigned      n, nbytes, k, c;
    logic             is_last;
    logic [MASK_W-1:0] keep;
    n = active_channels();
    nbytes = (n + 7) / 8;
    r = '0;
    if (layout_phase) begin
      k = 32'(byte_idx & 4'd7);
      if (k == 0) present = '0;
      keep = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      present = present | ((64'(w[7:0]) << (8 * k)) & keep);
      r.used = 1'b1;
      if (k + 1 >= nbytes) begin
        layout_phase = 1'b0;
        byte_idx = '0;
        cur_ch = '0;
        frames_left = (rate_reg == 0) ? 18'd1 : rate_reg;
      end else begin
        byte_idx = 4'(k + 1);
      end
    end else begin
      c = 32'(cur_ch);
      if (c >= n) c = n - 1;
      is_last = (c == n - 1);
      r.valid = 1'b1;
      r.chan = 6'(c);
      r.last = is_last;
      if (present[c]) begin
        r.value = 24'(to_q22(w));
        r.used = 1'b1;
      end
      if (is_last) begin
        cur_ch = '0;
        if (frames_left > 0) frames_left = frames_left - 18'd1;
        if (frames_left == 0) begin
          layout_phase = 1'b1;
          byte_idx = '0;
        end
      end else begin
        cur_ch = 6'(c + 1);
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // next stream word, shaped by what the decoder expects next
  function automatic logic [31:0] next_word();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(9) == 0) return w;
    if (layout_phase) begin
      case ($urandom_range(4))
        0: w[7:0] = 8'hFF;
        1: w[7:0] = 8'h00;
        2: w[7:0] = 8'(1 << $urandom_range(7));
        default: ;
      endcase
      return w;
    end
    case (fmt_reg)
      FMT_U8: begin
        case ($urandom_range(5))
          0: w[7:0] = 8'h00;
          1: w[7:0] = 8'hFF;
          2: w[7:0] = 8'h7F;
          default: ;
        endcase
      end
      FMT_S16: begin
        case ($urandom_range(5))
          0: w[15:0] = 16'h8000;
          1: w[15:0] = 16'h7FFF;
          2: w[15:0] = 16'hFFFF;
          default: ;
        endcase
      end
      default: begin
        case ($urandom_range(8))
          0: w[30:23] = 8'(100 + $urandom_range(27));
          1: w[30:23] = 8'(127 + $urandom_range(1));
          2: w[30:23] = 8'hFF;
          3: begin w[30:23] = 8'hFF; w[22:0] = '0; end
          4: w[30:0] = '0;
          5: w[30:23] = 8'(97 + $urandom_range(2));
          6: w[30:23] = 8'h00;
          7: begin w[30:23] = 8'(120 + $urandom_range(7)); w[1:0] = 2'b10; end
          default: ;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w, output logic used);
    int      gap;
    sample_t r;
    gap = (steady || $urandom_range(2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    file_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = decode_step(w);
    pending.push_back(r);
    used = r.used;
  endtask

  // offer a word until the decoder takes it
  task automatic feed(input logic [31:0] w);
    logic used;
    do send_word(w, used); while (!used);
  endtask

  task automatic run_stream(input int items);
    logic [31:0] w;
    logic        used;
    used = 1'b1;
    w = '0;
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(4) == 0);
      if (used) w = next_word();
      send_word(w, used);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CHANNEL_COUNT: cnt_reg = data[COUNT_W-1:0];
      REG_SAMPLE_RATE:   rate_reg = data[RATE_W-1:0];
      REG_SAMPLE_FORMAT: fmt_reg = data[FMT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_block(input logic [CFG_DATA_W-1:0] count, rate, fmt);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, count);
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_SAMPLE_FORMAT, fmt);
  endtask

  // reset values of count and format, two frames of unsigned 8-bit extremes
  task automatic test_reset_defaults();
    write_reg(REG_SAMPLE_RATE, 18'd2);
    feed(32'hA5C3_1203);
    feed(32'hABCD_EF00);
    feed(32'h1234_56FF);
    feed(32'h0000_007F);
    feed(32'hFFFF_FF80);
  endtask

  // count zero, rate zero, signed 16-bit ends, dropped and absent channels
  task automatic test_s16_edges();
    program_block(18'd0, 18'd0, 18'(FMT_S16));
    feed(32'h0000_0001);
    feed(32'h5A5A_8000);
    feed(32'h0000_00FF);
    feed(32'hFFFF_7FFF);
    feed(32'hFFFF_FF00);
    feed(32'h0000_0001);
    feed(32'h0000_0000);
  endtask

  task automatic test_float_edges();
    program_block(18'd1, 18'd9, 18'(FMT_F32));
    feed(32'h0000_0001);
    feed(32'h7FC0_0000);
    feed(32'h7F80_0000);
    feed(32'hFF80_0000);
    feed(32'h4000_0000);
    feed(32'hC000_0000);
    feed(32'h3F80_0000);
    feed(32'h3F00_0002);
    feed(32'h0040_0000);
    feed(32'h3000_0000);
  endtask

  // random settings changed at idle points, often in the middle of a block
  task automatic test_random_blocks();
    logic [FMT_W-1:0]      fmts[4];
    logic [CFG_DATA_W-1:0] count, rate, fmt;
    fmts = '{FMT_U8, FMT_S16, FMT_F32, FMT_CODE3};
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(9))
        0: count = 18'd0;
        1: count = 18'd64;
        2: count = 18'd127;
        3: count = 18'($urandom_range(127));
        default: count = 18'($urandom_range(1, 12));
      endcase
      rate = (count >= 32) ? 18'($urandom_range(1)) : 18'($urandom_range(3));
      if ($urandom_range(4) == 0) rate = 18'($urandom_range(4, 8));
      fmt = 18'(fmts[$urandom_range(3)]);
      if ($urandom_range(3) == 0) begin
        count[CFG_DATA_W-1:COUNT_W] = 11'($urandom());
        fmt[CFG_DATA_W-1:FMT_W] = 16'($urandom());
      end
      program_block(count, rate, fmt);
      run_stream($urandom_range(40, 110));
    end
  endtask

  // sample_rate 192000 with three channels; left running at the end
  task automatic test_max_rate();
    program_block(18'd1, 18'd1, 18'(FMT_F32));
    while (!layout_phase) run_stream(1);
    program_block(18'h3FF83, 18'd192000, 18'(FMT_CODE3));
    run_stream(40);
  endtask

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (steady || $urandom_range(3) != 0) begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(4);
    end else begin
      out_stall <= 1'b1;
      stall_hold <= gap_len() - 1;
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = pending.pop_front();
        check_field("sample_valid", 32'(want.valid), 32'(sample_valid));
        check_field("sample_value", 32'(want.value), 32'(sample_value));
        check_field("channel_index", 32'(want.chan), 32'(channel_index));
        check_field("frame_last", 32'(want.last), 32'(frame_last));
        check_field("word_consumed", 32'(want.used), 32'(word_consumed));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_s16_edges();
    test_float_edges();
    test_random_blocks();
    test_max_rate();
    in_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending.size() != 0) begin
      $error("%0d expected result items never arrived", pending.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/scbd_pkg.sv
sv/scbd_convert.sv
sv/scbd_sequencer.sv
sv/sparse_channel_block_decoder.sv
tb/testbench.sv
